// File: rtl/mp2pea_pkg.sv
// mp2pea_pkg: shared widths, FSM state and control struct for the MP2 pair-energy accumulator.
// No dependencies; used by mp2pea_muldiv and mp2_pair_energy_accumulator.
package mp2pea_pkg;

  localparam int unsigned IN_W      = 32;  // Q8.24 input fields
  localparam int unsigned DEN_W     = 34;  // exact sum of four Q8.24 values
  localparam int unsigned MCAND_W   = 33;  // |2I-K| < 3*2^31
  localparam int unsigned MPLIER_W  = 32;  // |I| <= 2^31
  localparam int unsigned DMAG_W    = 33;  // |D| < 2^33
  localparam int unsigned PROD_W    = MCAND_W + MPLIER_W;
  localparam int unsigned NUM_W     = 73;  // product < 2^64, shifted left by up to 9
  localparam int unsigned ACC_W     = 64;  // Q32.32 accumulators and quotients
  localparam int unsigned MUL_STEPS = MPLIER_W;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W     = 7;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_TERM,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Sequencer commands to the serial multiply/divide lanes.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic mul_last;
    logic div_step;
  } ctrl_t;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             sat;
  } sat_t;

endpackage

// File: rtl/mp2pea_muldiv.sv
// mp2pea_muldiv: one bit-serial lane, shift-add multiply then restoring divide by |D|.
// Depends on mp2pea_pkg for widths and the ctrl_t command struct.
module mp2pea_muldiv (
  input  logic                                clk_i,
  input  mp2pea_pkg::ctrl_t                   ctrl_i,
  input  logic [mp2pea_pkg::MCAND_W-1:0]      mcand_i,
  input  logic [mp2pea_pkg::MPLIER_W-1:0]     mplier_i,
  input  logic [mp2pea_pkg::DMAG_W-1:0]       dmag_i,
  input  logic                                shift8_i,
  output logic [mp2pea_pkg::ACC_W-1:0]        quot_o,
  output logic                                quot_ovf_o
);

  logic [mp2pea_pkg::MCAND_W-1:0]  mcand_q;
  logic [mp2pea_pkg::MPLIER_W-1:0] mplier_q;
  logic [mp2pea_pkg::MCAND_W-1:0]  hi_q;
  logic [mp2pea_pkg::MPLIER_W-1:0] lo_q;
  logic [mp2pea_pkg::NUM_W-1:0]    num_q;
  logic [mp2pea_pkg::DMAG_W-1:0]   rem_q;
  logic [mp2pea_pkg::ACC_W-1:0]    quot_q;
  logic                            qovf_q;

  logic [mp2pea_pkg::MCAND_W:0]    mul_sum;
  logic [mp2pea_pkg::PROD_W-1:0]   prod_next;
  logic [mp2pea_pkg::NUM_W-1:0]    num_init;
  logic [mp2pea_pkg::DMAG_W:0]     trial;
  logic                            trial_ge;

  // One multiplier bit per cycle: add, then shift the partial product right.
  assign mul_sum   = {1'b0, hi_q} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
  assign prod_next = {mul_sum, lo_q[mp2pea_pkg::MPLIER_W-1:1]};
  // Weight 1 scales by 2^8, weight 2 by 2^9.
  assign num_init  = shift8_i ? {1'b0, prod_next[mp2pea_pkg::ACC_W-1:0], 8'd0}
                              : {prod_next[mp2pea_pkg::ACC_W-1:0], 9'd0};

  // One quotient bit per cycle.
  assign trial    = {rem_q, num_q[mp2pea_pkg::NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, dmag_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      hi_q     <= '0;
      lo_q     <= '0;
    end else if (ctrl_i.mul_step) begin
      mplier_q <= mplier_q >> 1;
      hi_q     <= mul_sum[mp2pea_pkg::MCAND_W:1];
      lo_q     <= {mul_sum[0], lo_q[mp2pea_pkg::MPLIER_W-1:1]};
    end

    if (ctrl_i.mul_last) begin
      num_q  <= num_init;
      rem_q  <= '0;
      quot_q <= '0;
      qovf_q <= 1'b0;
    end else if (ctrl_i.div_step) begin
      num_q  <= num_q << 1;
      rem_q  <= trial_ge ? mp2pea_pkg::DMAG_W'(trial - {1'b0, dmag_i})
                         : trial[mp2pea_pkg::DMAG_W-1:0];
      quot_q <= {quot_q[mp2pea_pkg::ACC_W-2:0], trial_ge};
      qovf_q <= qovf_q | quot_q[mp2pea_pkg::ACC_W-1];
    end
  end

  assign quot_o     = quot_q;
  assign quot_ovf_o = qovf_q;

endmodule

// File: rtl/mp2_pair_energy_accumulator.sv
// MP2 pair-energy accumulator top level; depends on mp2pea_pkg and two mp2pea_muldiv lanes.
// Sequence: after an element is taken, a bit-serial multiply and divide, a saturate step
//   (ST_TERM) and an accumulate step (ST_ACC); a last element's result is registered from ST_EMIT.
// Input stalls until the sequencer is back in ST_IDLE, so no new element is taken before the
//   last one is done; a zero denominator skips the lanes, and ST_EMIT waits on output stalls.
// Reset (rst_ni low, async): sums and sticky flags clear, sequencer idles, no result pending.
module mp2_pair_energy_accumulator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Element channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    integral_ab_i,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    integral_ba_i,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    occ_energy_i_i,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    occ_energy_j_i,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    vir_energy_a_i,
  input  logic signed [mp2pea_pkg::IN_W-1:0]    vir_energy_b_i,
  input  logic                                  same_pair_i,
  input  logic                                  last_element_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mp2pea_pkg::ACC_W-1:0]   corr_energy_o,
  output logic signed [mp2pea_pkg::ACC_W-1:0]   os_energy_o,
  output logic                                  zero_denominator_o,
  output logic                                  saturated_o
);

  // ---------------------------------------------------------------------------
  // Saturation helpers
  // ---------------------------------------------------------------------------

  // Apply the sign to a quotient magnitude and clamp to the signed 64-bit range.
  function automatic mp2pea_pkg::sat_t term_sat(input logic [mp2pea_pkg::ACC_W-1:0] q,
                                                input logic ovf,
                                                input logic neg);
    mp2pea_pkg::sat_t r;
    r.value = neg ? (~q + mp2pea_pkg::ACC_W'(1)) : q;
    r.sat   = 1'b0;
    if (!neg && (ovf || q[mp2pea_pkg::ACC_W-1])) begin
      r.value = mp2pea_pkg::ACC_MAX;
      r.sat   = 1'b1;
    end
    // Exactly 2^63 negated is the most negative value and does not count as saturation.
    if (neg && (ovf || (q[mp2pea_pkg::ACC_W-1] && (q[mp2pea_pkg::ACC_W-2:0] != '0)))) begin
      r.value = mp2pea_pkg::ACC_MIN;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

  // Two's-complement add that clamps on signed overflow.
  function automatic mp2pea_pkg::sat_t add_sat(input logic [mp2pea_pkg::ACC_W-1:0] a,
                                               input logic [mp2pea_pkg::ACC_W-1:0] b);
    mp2pea_pkg::sat_t             r;
    logic [mp2pea_pkg::ACC_W-1:0] s;
    s     = a + b;
    r.sat = (a[mp2pea_pkg::ACC_W-1] == b[mp2pea_pkg::ACC_W-1]) &&
            (s[mp2pea_pkg::ACC_W-1] != a[mp2pea_pkg::ACC_W-1]);
    if (r.sat) begin
      r.value = a[mp2pea_pkg::ACC_W-1] ? mp2pea_pkg::ACC_MIN : mp2pea_pkg::ACC_MAX;
    end else begin
      r.value = s;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  mp2pea_pkg::state_e             state_q, state_d;
  logic [mp2pea_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  mp2pea_pkg::ctrl_t              ctrl;

  logic                           in_acc;
  logic                           emit_go;

  logic [mp2pea_pkg::DEN_W-1:0]   den;
  logic [mp2pea_pkg::DEN_W-1:0]   den_mag;
  logic [mp2pea_pkg::DEN_W-1:0]   aval;
  logic [mp2pea_pkg::DEN_W-1:0]   aval_mag;
  logic [mp2pea_pkg::IN_W:0]      ival_mag;
  logic                           den_zero;

  // Per-element captures
  logic                           same_pair_q;
  logic                           last_q;
  logic                           neg1_q;
  logic                           dneg_q;
  logic [mp2pea_pkg::DMAG_W-1:0]  dmag_q;

  // Lane results and signed terms
  logic [mp2pea_pkg::ACC_W-1:0]   quot1, quot2;
  logic                           qovf1, qovf2;
  mp2pea_pkg::sat_t               term1_sat, term2_sat;
  logic [mp2pea_pkg::ACC_W-1:0]   term1_q, term2_q;

  // Running state
  logic [mp2pea_pkg::ACC_W-1:0]   corr_sum_q;
  logic [mp2pea_pkg::ACC_W-1:0]   os_sum_q;
  logic                           zdiv_q;
  logic                           ovf_q;
  mp2pea_pkg::sat_t               corr_add, os_add;

  // Result register
  logic                           out_valid_q;
  logic [mp2pea_pkg::ACC_W-1:0]   corr_out_q;
  logic [mp2pea_pkg::ACC_W-1:0]   os_out_q;
  logic                           zdiv_out_q;
  logic                           sat_out_q;

  // ---------------------------------------------------------------------------
  // Input decode: denominator, 2I-K and magnitudes, all exact
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != mp2pea_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign den  = {{2{occ_energy_i_i[mp2pea_pkg::IN_W-1]}}, occ_energy_i_i}
              + {{2{occ_energy_j_i[mp2pea_pkg::IN_W-1]}}, occ_energy_j_i}
              - {{2{vir_energy_a_i[mp2pea_pkg::IN_W-1]}}, vir_energy_a_i}
              - {{2{vir_energy_b_i[mp2pea_pkg::IN_W-1]}}, vir_energy_b_i};
  assign aval = {integral_ab_i[mp2pea_pkg::IN_W-1], integral_ab_i, 1'b0}
              - {{2{integral_ba_i[mp2pea_pkg::IN_W-1]}}, integral_ba_i};

  assign den_mag  = den[mp2pea_pkg::DEN_W-1] ? (~den + 1'b1) : den;
  assign aval_mag = aval[mp2pea_pkg::DEN_W-1] ? (~aval + 1'b1) : aval;
  assign ival_mag = integral_ab_i[mp2pea_pkg::IN_W-1]
                  ? (~{1'b1, integral_ab_i} + 1'b1)
                  : {1'b0, integral_ab_i};
  assign den_zero = (den == '0);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign emit_go = (state_q == mp2pea_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mp2pea_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl    = '0;
    case (state_q)
      mp2pea_pkg::ST_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          cnt_d     = '0;
          // A zero denominator adds nothing: skip straight to the accumulate step.
          state_d   = den_zero ? mp2pea_pkg::ST_ACC : mp2pea_pkg::ST_MUL;
        end
      end
      mp2pea_pkg::ST_MUL: begin
        ctrl.mul_step = 1'b1;
        if (cnt_q == mp2pea_pkg::CNT_W'(mp2pea_pkg::MUL_STEPS - 1)) begin
          ctrl.mul_last = 1'b1;
          cnt_d         = '0;
          state_d       = mp2pea_pkg::ST_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mp2pea_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (cnt_q == mp2pea_pkg::CNT_W'(mp2pea_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = mp2pea_pkg::ST_TERM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mp2pea_pkg::ST_TERM: begin
        state_d = mp2pea_pkg::ST_ACC;
      end
      mp2pea_pkg::ST_ACC: begin
        state_d = last_q ? mp2pea_pkg::ST_EMIT : mp2pea_pkg::ST_IDLE;
      end
      mp2pea_pkg::ST_EMIT: begin
        // Hold until the result register is free or being drained.
        if (emit_go) begin
          state_d = mp2pea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mp2pea_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Serial lanes: corr lane computes |2I-K|*|I|, second lane |I|*|I|, both over |D|
  // ---------------------------------------------------------------------------
  mp2pea_muldiv u_corr_lane (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mcand_i    (aval_mag[mp2pea_pkg::MCAND_W-1:0]),
    .mplier_i   (ival_mag[mp2pea_pkg::MPLIER_W-1:0]),
    .dmag_i     (dmag_q),
    .shift8_i   (same_pair_q),
    .quot_o     (quot1),
    .quot_ovf_o (qovf1)
  );

  mp2pea_muldiv u_os_lane (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mcand_i    (ival_mag[mp2pea_pkg::MCAND_W-1:0]),
    .mplier_i   (ival_mag[mp2pea_pkg::MPLIER_W-1:0]),
    .dmag_i     (dmag_q),
    .shift8_i   (same_pair_q),
    .quot_o     (quot2),
    .quot_ovf_o (qovf2)
  );

  assign term1_sat = term_sat(quot1, qovf1, neg1_q);
  assign term2_sat = term_sat(quot2, qovf2, dneg_q);

  // Capture per-element operands and zero the terms; they stay zero when the denominator vanished.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      same_pair_q <= same_pair_i;
      last_q      <= last_element_i;
      neg1_q      <= aval[mp2pea_pkg::DEN_W-1] ^ integral_ab_i[mp2pea_pkg::IN_W-1]
                   ^ den[mp2pea_pkg::DEN_W-1];
      dneg_q      <= den[mp2pea_pkg::DEN_W-1];
      dmag_q      <= den_mag[mp2pea_pkg::DMAG_W-1:0];
      term1_q     <= '0;
      term2_q     <= '0;
    end else if (state_q == mp2pea_pkg::ST_TERM) begin
      term1_q <= term1_sat.value;
      term2_q <= term2_sat.value;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating accumulators and sticky flags
  // ---------------------------------------------------------------------------
  assign corr_add = add_sat(corr_sum_q, term1_q);
  assign os_add   = add_sat(os_sum_q, term2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_sum_q <= '0;
      os_sum_q   <= '0;
      zdiv_q     <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (emit_go) begin
      // Result is handed off: start the next sum from scratch.
      corr_sum_q <= '0;
      os_sum_q   <= '0;
      zdiv_q     <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      if (in_acc && den_zero) begin
        zdiv_q <= 1'b1;
      end
      if ((state_q == mp2pea_pkg::ST_TERM) && (term1_sat.sat || term2_sat.sat)) begin
        ovf_q <= 1'b1;
      end
      if (state_q == mp2pea_pkg::ST_ACC) begin
        corr_sum_q <= corr_add.value;
        os_sum_q   <= os_add.value;
        if (corr_add.sat || os_add.sat) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds one transaction while the consumer stalls
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      corr_out_q <= corr_sum_q;
      os_out_q   <= os_sum_q;
      zdiv_out_q <= zdiv_q;
      sat_out_q  <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign corr_energy_o      = corr_out_q;
  assign os_energy_o        = os_out_q;
  assign zero_denominator_o = zdiv_out_q;
  assign saturated_o        = sat_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mul_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mp2pea_pkg::ST_MUL) |->
      (cnt_q < mp2pea_pkg::CNT_W'(mp2pea_pkg::MUL_STEPS)))
    else $error("multiply step count out of range");

  a_div_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mp2pea_pkg::ST_DIV) |->
      (cnt_q < mp2pea_pkg::CNT_W'(mp2pea_pkg::DIV_STEPS)))
    else $error("divide step count out of range");

  a_zero_den_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && den_zero) |=>
      (state_q == mp2pea_pkg::ST_ACC) && (term1_q == '0) && (term2_q == '0) && zdiv_q)
    else $error("zero denominator element did not bypass the lanes");

  a_acc_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == mp2pea_pkg::ST_ACC) && (corr_add.sat || os_add.sat)) |=> ovf_q)
    else $error("accumulator saturation not recorded");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q && (corr_sum_q == '0) && (os_sum_q == '0) && !zdiv_q && !ovf_q)
    else $error("sum state not cleared after result hand-off");

endmodule
